[rtl/lcgbr_pkg.sv]
// Shared constants, types and state encoding for the bounded LCG random block.
`default_nettype none
package lcgbr_pkg;

  localparam int unsigned SEED_W  = 32;
  localparam int unsigned LIMIT_W = 32;
  localparam int unsigned RAND_W  = 31;

  // Configuration port: byte address, one 32-bit register per word.
  localparam int unsigned CFG_AW  = 3;
  localparam int unsigned CFG_DW  = 32;
  localparam int unsigned CFG_IW  = CFG_AW - 2;

  localparam logic [CFG_IW-1:0]  CFG_IDX_SEED_VALUE = '0;

  localparam logic [SEED_W-1:0]  LCG_MULT  = 32'h015A_4E35;
  localparam logic [SEED_W-1:0]  LCG_INC   = 32'h0000_0001;
  localparam logic [LIMIT_W-1:0] LOW_RANGE = 32'h0000_7FFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_START,
    ST_DIV,
    ST_FIN
  } lcgbr_state_t;

endpackage
`default_nettype wire

[rtl/lcgbr_if.sv]
// Valid/ready channel interfaces for the limit beat and the result beat.
`default_nettype none
interface lcgbr_in_if;
  import lcgbr_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [LIMIT_W-1:0] upper_limit;

  modport source (output valid, output upper_limit, input ready);
  modport sink   (input valid, input upper_limit, output ready);
endinterface

interface lcgbr_out_if;
  import lcgbr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic        [RAND_W-1:0] random_value;
  logic signed [SEED_W-1:0] current_seed;

  modport source (output valid, output random_value, output current_seed, input ready);
  modport sink   (input valid, input random_value, input current_seed, output ready);
endinterface
`default_nettype wire

[rtl/lcgbr_div.sv]
// Bit-serial restoring divider that returns the remainder, one quotient bit per cycle.
`default_nettype none
module lcgbr_div #(
  parameter int unsigned Width = lcgbr_pkg::SEED_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [Width-1:0] dividend,
  input  wire logic [Width-2:0] divisor,
  output logic                  busy,
  output logic                  done,
  output logic      [Width-2:0] remainder
);
  import lcgbr_pkg::*;

  localparam int unsigned CntW = $clog2(Width);

  logic [Width-1:0] dvd_r, dvd_nxt;
  logic [Width-2:0] dvs_r, dvs_nxt;
  logic [Width-1:0] rem_r, rem_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;

  logic [Width-1:0] rem_sh;
  logic [Width:0]   diff;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign rem_sh = {rem_r[Width-2:0], dvd_r[Width-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = CntW'(Width - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[Width-2:0], 1'b0};
      rem_nxt = diff[Width] ? rem_sh : diff[Width-1:0];
      cnt_nxt = cnt_r - CntW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign busy      = busy_r;
  assign done      = busy_r && (cnt_r == '0);
  assign remainder = rem_r[Width-2:0];

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !busy_r)
    else $error("divider still busy after last step");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && dvs_r != '0) |-> (rem_r < {1'b0, dvs_r}))
    else $error("partial remainder not below divisor");

endmodule
`default_nettype wire

[rtl/lcg_bounded_random_unit.sv]
// Top level: LCG seed register, sequencer, APB seed port and result register.
// Each limit beat advances a 32-bit linear congruential seed (x*0x015A4E35+1)
// and returns a value in 0 .. limit-1 together with the new seed. A positive
// limit passes through the seed multiply, the divider load, the bit-serial
// remainder unit (one quotient bit per cycle) and the result write, which
// waits while the output register holds a result that is not yet taken.
// A zero or negative limit returns 0 and the unchanged seed.
// The block takes one limit at a time; the next limit is accepted as soon as
// the result is in the output register, even while that result waits.
// Writing reg 0 (byte address 0) loads the seed; reads return the last write.
`default_nettype none
module lcg_bounded_random_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  lcgbr_in_if.sink                          in_ch,
  lcgbr_out_if.source                       out_ch,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [lcgbr_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [lcgbr_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic      [lcgbr_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                              cfg_pready
);
  import lcgbr_pkg::*;

  lcgbr_state_t st_r, st_nxt;

  logic [SEED_W-1:0]  seed_r, seed_nxt;
  logic [SEED_W-1:0]  seed_value_r, seed_value_nxt;
  logic [LIMIT_W-1:0] lim_r, lim_nxt;
  logic               pos_r, pos_nxt;
  logic [RAND_W-1:0]  out_rand_r, out_rand_nxt;
  logic [SEED_W-1:0]  out_seed_r, out_seed_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               in_acc;
  logic               in_pos;
  logic               cfg_wr;
  logic               seed_adv;
  logic               div_start;
  logic               out_load;
  logic               slot_free;
  logic [SEED_W-1:0]  seed_prod;
  logic [SEED_W-1:0]  seed_mag;
  logic [SEED_W-1:0]  div_dvd;
  logic               div_busy;
  logic               div_done;
  logic [RAND_W-1:0]  div_rem;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign in_pos    = !in_ch.upper_limit[LIMIT_W-1] && (in_ch.upper_limit != '0);
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                     && (cfg_paddr[CFG_AW-1:2] == CFG_IDX_SEED_VALUE);
  assign slot_free = !out_valid_r || out_ch.ready;

  // Low 32 bits of the product only; the seed wraps mod 2^32.
  assign seed_prod = SEED_W'(seed_r * LCG_MULT) + LCG_INC;
  // Most negative seed maps to 2^31, which still fits unsigned.
  assign seed_mag  = seed_r[SEED_W-1] ? (~seed_r + SEED_W'(1)) : seed_r;
  assign div_dvd   = (lim_r < LOW_RANGE) ? {16'h0000, seed_mag[SEED_W-1:16]} : seed_mag;

  lcgbr_div #(
    .Width (SEED_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (lim_r[RAND_W-1:0]),
    .busy      (div_busy),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          st_nxt = in_pos ? ST_MUL : ST_FIN;
        end
      end
      ST_MUL:   st_nxt = ST_START;
      ST_START: st_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          st_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ch.ready = 1'b0;
    seed_adv    = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    unique case (st_r)
      ST_IDLE:  in_ch.ready = 1'b1;
      ST_MUL:   seed_adv    = 1'b1;
      ST_START: div_start   = 1'b1;
      ST_DIV:   ;
      ST_FIN:   out_load    = slot_free;
      default:  ;
    endcase
  end

  always_comb begin
    seed_nxt       = seed_r;
    seed_value_nxt = seed_value_r;
    lim_nxt        = lim_r;
    pos_nxt        = pos_r;
    out_rand_nxt   = out_rand_r;
    out_seed_nxt   = out_seed_r;
    out_valid_nxt  = out_valid_r;

    if (cfg_wr) begin
      seed_value_nxt = cfg_pwdata[SEED_W-1:0];
      seed_nxt       = cfg_pwdata[SEED_W-1:0];
    end else if (seed_adv) begin
      seed_nxt = seed_prod;
    end

    if (in_acc) begin
      lim_nxt = in_ch.upper_limit;
      pos_nxt = in_pos;
    end

    // Drop the taken beat, then load a new one if finished.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_rand_nxt  = pos_r ? div_rem : '0;
      out_seed_nxt  = seed_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      seed_r       <= '0;
      seed_value_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      seed_r       <= seed_nxt;
      seed_value_r <= seed_value_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lim_r      <= lim_nxt;
    pos_r      <= pos_nxt;
    out_rand_r <= out_rand_nxt;
    out_seed_r <= out_seed_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.random_value = out_rand_r;
  assign out_ch.current_seed = out_seed_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[CFG_AW-1:2] == CFG_IDX_SEED_VALUE) ?
                      CFG_DW'(seed_value_r) : '0;

  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("limit accepted while previous one still in work");

  a_div_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIV) |-> div_busy)
    else $error("sequencer waits on an idle divider");

  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_FIN) |-> !div_busy)
    else $error("result written while divider still runs");

  a_rand_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && pos_r) |-> (div_rem < lim_r[RAND_W-1:0]))
    else $error("random value not below limit");

endmodule
`default_nettype wire

[verif/tb.sv]
// Self-checking bench for the bounded LCG random block: queued limit beats, modeled seed.
module tb;
  import lcgbr_pkg::*;

  typedef struct packed {
    logic [RAND_W-1:0] random_value;
    logic [SEED_W-1:0] current_seed;
  } draw_t;

  // Any index past the seed register must be ignored by the block.
  localparam logic [CFG_IW-1:0] CFG_IDX_SPARE = 1;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  lcgbr_in_if  in_bus ();
  lcgbr_out_if out_bus ();

  lcg_bounded_random_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_bus),
    .out_ch      (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  logic [SEED_W-1:0]         lcg_seed;
  logic signed [LIMIT_W-1:0] limit_queue[$];
  draw_t                     draw_expect[$];
  bit                        calm;
  int                        errors;
  int                        n_sent;
  int                        n_checked;
  int                        n_loads;
  int                        n_nonpos;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb: done, errors");
    $finish;
  end

  // Advance the modeled generator for one limit and form the result it gives.
  function automatic draw_t lcg_draw(input logic [LIMIT_W-1:0] limit);
    draw_t             d;
    logic [SEED_W-1:0] mag;
    logic [SEED_W-1:0] rem;
    rem = '0;
    if (!limit[LIMIT_W-1] && limit != '0) begin
      lcg_seed = lcg_seed * LCG_MULT + LCG_INC;
      mag = lcg_seed[SEED_W-1] ? (32'd0 - lcg_seed) : lcg_seed;
      if (limit < LOW_RANGE) rem = (mag >> 16) % limit;
      else rem = mag % limit;
    end else begin
      n_nonpos++;
    end
    d.random_value = rem[RAND_W-1:0];
    d.current_seed = lcg_seed;
    return d;
  endfunction

  function automatic logic [LIMIT_W-1:0] rand_limit();
    int unsigned w;
    case ($urandom_range(9))
      0: return $urandom;
      1: return -$urandom_range(3);
      2, 3, 4: return $urandom_range(32'h7FFE, 1);
      5: return $urandom_range(32'h8002, 32'h7FFC);
      6: begin
        w = $urandom_range(31, 1);
        return $urandom & ((32'd1 << w) - 32'd1);
      end
      7: return 32'h7FFF_FFFF - $urandom_range(15);
      default: return $urandom & 32'h7FFF_FFFF;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("tb: mismatch on %s: got %h, want %h", what, got, want);
    errors++;
  endtask

  task automatic cfg_write(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == CFG_IDX_SEED_VALUE) begin
      lcg_seed = value;
      n_loads++;
    end
  endtask

  // Hold until every queued limit has gone out and every result has come back.
  task automatic drain();
    while (limit_queue.size() != 0 || in_bus.valid || draw_expect.size() != 0)
      @(posedge clk);
  endtask

  // Driver: a stalled beat is held; otherwise offer the next limit or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        draw_expect.push_back(lcg_draw(in_bus.upper_limit));
        n_sent++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (limit_queue.size() != 0 && (calm || $urandom_range(99) >= 7)) begin
          in_bus.valid       <= 1'b1;
          in_bus.upper_limit <= limit_queue.pop_front();
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest expectation.
  always @(posedge clk) begin
    draw_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (draw_expect.size() == 0) begin
          report_mismatch("unexpected result seed", out_bus.current_seed, '0);
        end else begin
          want = draw_expect.pop_front();
          n_checked++;
          if (out_bus.random_value !== want.random_value)
            report_mismatch("random_value", 32'(out_bus.random_value),
                            32'(want.random_value));
          if (out_bus.current_seed !== want.current_seed)
            report_mismatch("current_seed", out_bus.current_seed, want.current_seed);
        end
      end
      out_bus.ready <= calm || ($urandom_range(99) >= 7);
    end
  end

  initial begin
    logic [SEED_W-1:0] inv;
    logic [SEED_W-1:0] pre_min;
    clk                = 1'b0;
    rst_n              = 1'b0;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;
    in_bus.valid       = 1'b0;
    in_bus.upper_limit = '0;
    out_bus.ready      = 1'b0;
    lcg_seed           = '0;
    calm               = 1'b0;

    // Seed whose next step lands on the most negative value.
    inv = LCG_MULT;
    repeat (5) inv = inv * (32'd2 - LCG_MULT * inv);
    pre_min = 32'h7FFF_FFFF * inv;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes and both sides of the low-range boundary from reset seed.
    limit_queue.push_back(32'h0000_0000);
    limit_queue.push_back(32'hFFFF_FFFF);
    limit_queue.push_back(32'h8000_0000);
    limit_queue.push_back(32'h0000_0001);
    limit_queue.push_back(32'h0000_0002);
    limit_queue.push_back(32'h0000_7FFE);
    limit_queue.push_back(32'h0000_7FFF);
    limit_queue.push_back(32'h0000_8000);
    limit_queue.push_back(32'h7FFF_FFFF);
    limit_queue.push_back(32'h0000_0003);
    limit_queue.push_back(32'd1000);
    drain();
    cfg_write(CFG_IDX_SEED_VALUE, 32'h7FFF_FFFF);
    limit_queue.push_back(32'h7FFF_FFFF);
    limit_queue.push_back(32'h0000_7FFE);
    limit_queue.push_back(32'h0000_0000);
    drain();
    // Most negative seed held by a nonpositive limit, then stepped.
    cfg_write(CFG_IDX_SEED_VALUE, 32'h8000_0000);
    limit_queue.push_back(32'h0000_0000);
    limit_queue.push_back(32'h1234_5678);
    drain();
    cfg_write(CFG_IDX_SEED_VALUE, 32'hFFFF_FFFF);
    limit_queue.push_back(32'd5);
    drain();
    // Magnitude of the most negative seed, large and small limit.
    cfg_write(CFG_IDX_SEED_VALUE, pre_min);
    limit_queue.push_back(32'h7FFF_FFFF);
    drain();
    cfg_write(CFG_IDX_SEED_VALUE, pre_min);
    limit_queue.push_back(32'h0000_7FFE);
    drain();
    // Out-of-range register index: seed must stay put.
    cfg_write(CFG_IDX_SPARE, 32'hDEAD_BEEF);
    limit_queue.push_back(32'd7);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: cfg_write(CFG_IDX_SEED_VALUE, 32'h0000_0000);
        1: cfg_write(CFG_IDX_SEED_VALUE, 32'h7FFF_FFFF);
        2: cfg_write(CFG_IDX_SEED_VALUE, 32'h8000_0000);
        3: cfg_write(CFG_IDX_SEED_VALUE, 32'hFFFF_FFFF);
        default: cfg_write(CFG_IDX_SEED_VALUE, $urandom);
      endcase
      if (ph == 5) cfg_write(CFG_IDX_SPARE, $urandom);
      calm = (ph == 6);
      repeat (250) limit_queue.push_back(rand_limit());
      drain();
    end
    calm = 1'b0;

    repeat (40) @(posedge clk);
    if (draw_expect.size() != 0) begin
      $display("tb: %0d expected results never arrived", draw_expect.size());
      errors++;
    end
    $display("tb: %0d limit beats sent (%0d zero or negative), %0d results checked",
             n_sent, n_nonpos, n_checked);
    $display("tb: %0d seed loads incl. extremes and most-negative preimage, %0d errors",
             n_loads, errors);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
rtl/lcgbr_pkg.sv
rtl/lcgbr_if.sv
rtl/lcgbr_div.sv
rtl/lcg_bounded_random_unit.sv
verif/tb.sv
